>>> rtl/core/cbqf_pkg.sv
package cbqf_pkg;

	localparam logic [1:0] FN_FILTER = 2'd0;
	localparam logic [1:0] FN_COEF   = 2'd1;
	localparam logic [1:0] FN_SWAP   = 2'd2;

	localparam logic CFG_NUM_SECTIONS   = 1'b0;
	localparam logic CFG_OVERFLOW_LIMIT = 1'b1;

	localparam logic [2:0]  NUM_SECTIONS_RST   = 3'd2;
	localparam logic [30:0] OVERFLOW_LIMIT_RST = 31'd1000000;

	localparam int SLOTS     = 6;
	localparam int TAPS      = 4;
	localparam int FRAC_BITS = 28;

	localparam logic [2:0] SLOT_B0 = 3'd0;
	localparam logic [2:0] SLOT_B1 = 3'd1;
	localparam logic [2:0] SLOT_B2 = 3'd2;
	localparam logic [2:0] SLOT_A0 = 3'd3;
	localparam logic [2:0] SLOT_A1 = 3'd4;
	localparam logic [2:0] SLOT_A2 = 3'd5;

	localparam logic [1:0] TAP_X1 = 2'd0;
	localparam logic [1:0] TAP_X2 = 2'd1;
	localparam logic [1:0] TAP_Y1 = 2'd2;
	localparam logic [1:0] TAP_Y2 = 2'd3;

	// per-section micro-steps
	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_RB0   = 4'd1;
	localparam logic [3:0] ST_MB0   = 4'd2;
	localparam logic [3:0] ST_MB1   = 4'd3;
	localparam logic [3:0] ST_MB2   = 4'd4;
	localparam logic [3:0] ST_ACC2  = 4'd5;
	localparam logic [3:0] ST_CT    = 4'd6;
	localparam logic [3:0] ST_MA0   = 4'd7;
	localparam logic [3:0] ST_MA1   = 4'd8;
	localparam logic [3:0] ST_MA2   = 4'd9;
	localparam logic [3:0] ST_ACC5  = 4'd10;
	localparam logic [3:0] ST_Y     = 4'd11;
	localparam logic [3:0] ST_WY    = 4'd12;
	localparam logic [3:0] ST_LAST  = ST_WY;

	typedef struct packed {
		logic       load_item;
		logic       coef_wr;
		logic       swap;
		logic       run;
		logic       out_load;
		logic [3:0] step;
		logic [2:0] sec;
	} cmd_t;

	typedef struct packed {
		logic [3:0] n_sec;
	} stat_t;

endpackage

>>> rtl/core/cbqf_ctrl.sv
module cbqf_ctrl #(
	parameter int MAX_SECTIONS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     in_func,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  cbqf_pkg::stat_t stat,
	output cbqf_pkg::cmd_t  cmd
);
	import cbqf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [3:0] step_q;
	logic [2:0] sec_q;
	logic       out_valid_q;
	logic       accept;
	logic       last_sec;
	logic       can_load;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign last_sec  = ({1'b0, sec_q} == stat.n_sec - 4'd1);
	assign can_load  = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.load_item = accept && (in_func == FN_FILTER);
		cmd.coef_wr   = accept && (in_func == FN_COEF);
		cmd.swap      = accept && (in_func == FN_SWAP);
		cmd.run       = (state_q == S_RUN);
		cmd.out_load  = (state_q == S_DONE) && can_load;
		cmd.step      = step_q;
		cmd.sec       = sec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_CLR;
			sec_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= ST_CLR;
					sec_q  <= '0;
					if (cmd.load_item) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (step_q == ST_LAST) begin
						step_q <= ST_CLR;
						if (last_sec) begin
							state_q <= S_DONE;
						end else begin
							sec_q <= sec_q + 3'd1;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DONE: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) step_q <= ST_LAST)
		else $error("step counter past last step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> ({1'b0, sec_q} < stat.n_sec))
		else $error("section index beyond configured count");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result load not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !can_load) |=> (state_q == S_DONE))
		else $error("left done state with result register full");

endmodule

>>> rtl/core/cbqf_dpath.sv
module cbqf_dpath #(
	parameter int MAX_SECTIONS = 4,
	parameter int NUM_CHANNELS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cbqf_pkg::cmd_t      cmd,
	output cbqf_pkg::stat_t     stat,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_chan,
	input  logic signed [23:0]  in_sample,
	input  logic [1:0]          in_section,
	input  logic [2:0]          in_slot,
	input  logic signed [31:0]  in_coef,
	output logic signed [31:0]  out_sample,
	output logic                out_sat,
	output logic                out_cleared
);
	import cbqf_pkg::*;

	localparam int CDEPTH = 2 * MAX_SECTIONS * SLOTS;
	localparam int CAW    = $clog2(CDEPTH);
	localparam int CHD    = MAX_SECTIONS * TAPS;
	localparam int DDEPTH = NUM_CHANNELS * CHD;
	localparam int DAW    = $clog2(DDEPTH);
	localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

	logic [2:0]          nsec_q;
	logic [30:0]         limit_q;
	logic                bank_q;
	logic                ovf_q;
	logic                ch_q;
	logic                sat_q;
	logic                clr_q;
	logic signed [31:0]  x_q;
	logic signed [31:0]  ct_q;
	logic signed [31:0]  coef_rd_q;
	logic signed [31:0]  dly_rd_q;
	logic                dly_v_q;
	logic signed [63:0]  prod_s1;
	logic signed [65:0]  acc_q;
	logic signed [31:0]  out_sample_q;
	logic                out_sat_q;
	logic                out_clr_q;

	logic signed [31:0]  coef_mem [CDEPTH];
	logic signed [31:0]  dly_mem  [DDEPTH];
	logic [DDEPTH-1:0]   dly_vld_q;

	logic [3:0]          n_clamp;
	logic [2:0]          rslot;
	logic [1:0]          rtap;
	logic [1:0]          wtap;
	logic                dly_we;
	logic signed [31:0]  dly_wdata;
	logic [CAW-1:0]      c_raddr;
	logic [CAW-1:0]      c_waddr;
	logic                c_we;
	logic [DAW-1:0]      d_raddr;
	logic [DAW-1:0]      d_waddr;
	logic                ch_eff;
	logic signed [31:0]  dly_op;
	logic signed [31:0]  op_a;
	logic signed [65:0]  rnd_sum;
	logic signed [37:0]  rnd;
	logic signed [31:0]  rnd_sat;
	logic                rnd_ovs;
	logic [32:0]         rnd_mag;
	logic                over_lim;
	logic                do_clr;

	always_comb begin
		if (nsec_q == 3'd0) begin
			n_clamp = 4'd1;
		end else if ({1'b0, nsec_q} > 4'(MAX_SECTIONS)) begin
			n_clamp = 4'(MAX_SECTIONS);
		end else begin
			n_clamp = {1'b0, nsec_q};
		end
	end
	assign stat.n_sec = n_clamp;

	assign ch_eff = (NUM_CHANNELS == 1) ? 1'b0 : ch_q;
	assign dly_op = dly_v_q ? dly_rd_q : 32'sd0;

	always_comb begin
		rslot = SLOT_B0;
		rtap  = TAP_X1;
		case (cmd.step)
			ST_MB0:  begin rslot = SLOT_B1; rtap = TAP_X1; end
			ST_MB1:  begin rslot = SLOT_B2; rtap = TAP_X2; end
			ST_CT:   rslot = SLOT_A0;
			ST_MA0:  begin rslot = SLOT_A1; rtap = TAP_Y1; end
			ST_MA1:  begin rslot = SLOT_A2; rtap = TAP_Y2; end
			default: begin rslot = SLOT_B0; rtap = TAP_X1; end
		endcase
	end

	always_comb begin
		dly_we    = 1'b0;
		wtap      = TAP_X2;
		dly_wdata = dly_op;
		if (cmd.run) begin
			case (cmd.step)
				ST_MB1: begin dly_we = 1'b1; wtap = TAP_X2; dly_wdata = dly_op; end
				ST_MB2: begin dly_we = 1'b1; wtap = TAP_X1; dly_wdata = x_q; end
				ST_MA1: begin dly_we = 1'b1; wtap = TAP_Y2; dly_wdata = dly_op; end
				ST_WY:  begin dly_we = 1'b1; wtap = TAP_Y1; dly_wdata = x_q; end
				default: dly_we = 1'b0;
			endcase
		end
	end

	assign c_raddr = CAW'((int'(bank_q) * MAX_SECTIONS + int'(cmd.sec)) * SLOTS
		+ int'(rslot));
	assign c_waddr = CAW'((int'(!bank_q) * MAX_SECTIONS + int'(in_section)) * SLOTS
		+ int'(in_slot));
	assign c_we    = cmd.coef_wr && (int'(in_section) < MAX_SECTIONS)
		&& (int'(in_slot) < SLOTS);
	assign d_raddr = DAW'((int'(ch_eff) * MAX_SECTIONS + int'(cmd.sec)) * TAPS
		+ int'(rtap));
	assign d_waddr = DAW'((int'(ch_eff) * MAX_SECTIONS + int'(cmd.sec)) * TAPS
		+ int'(wtap));

	always_ff @(posedge clk) begin
		if (c_we) begin
			coef_mem[c_waddr] <= in_coef;
		end
		coef_rd_q <= coef_mem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (dly_we) begin
			dly_mem[d_waddr] <= dly_wdata;
		end
		dly_rd_q <= dly_mem[d_raddr];
	end

	assign do_clr = cmd.run && (cmd.step == ST_CLR) && ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_vld_q <= '0;
			dly_v_q   <= 1'b0;
		end else begin
			dly_v_q <= dly_vld_q[d_raddr];
			if (do_clr) begin
				for (int i = 0; i < DDEPTH; i++) begin
					if (i / CHD == int'(ch_eff)) begin
						dly_vld_q[i] <= 1'b0;
					end
				end
			end else if (dly_we) begin
				dly_vld_q[d_waddr] <= 1'b1;
			end
		end
	end

	always_comb begin
		case (cmd.step)
			ST_MB0:  op_a = x_q;
			ST_MA0:  op_a = ct_q;
			default: op_a = dly_op;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * coef_rd_q;
	end

	assign rnd_sum = acc_q + HALF;
	assign rnd     = rnd_sum[65:FRAC_BITS];
	always_comb begin
		rnd_ovs = 1'b0;
		rnd_sat = rnd[31:0];
		if (rnd > 38'sd2147483647) begin
			rnd_ovs = 1'b1;
			rnd_sat = 32'sh7FFFFFFF;
		end else if (rnd < -38'sd2147483648) begin
			rnd_ovs = 1'b1;
			rnd_sat = 32'sh80000000;
		end
	end
	assign rnd_mag  = rnd_sat[31] ? -{rnd_sat[31], rnd_sat} : {rnd_sat[31], rnd_sat};
	assign over_lim = rnd_mag > {2'b00, limit_q};

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			x_q  <= 32'(in_sample);
			ch_q <= in_chan;
		end else if (cmd.run) begin
			case (cmd.step)
				ST_CLR:  acc_q <= '0;
				ST_MB1, ST_MB2, ST_ACC2, ST_MA1: acc_q <= acc_q + 66'(prod_s1);
				ST_MA2, ST_ACC5: acc_q <= acc_q - 66'(prod_s1);
				ST_CT: begin
					ct_q  <= rnd_sat;
					acc_q <= '0;
				end
				ST_Y:    x_q <= rnd_sat;
				default: acc_q <= acc_q;
			endcase
		end
		if (cmd.out_load) begin
			out_sample_q <= x_q;
			out_sat_q    <= sat_q;
			out_clr_q    <= clr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsec_q  <= NUM_SECTIONS_RST;
			limit_q <= OVERFLOW_LIMIT_RST;
			bank_q  <= 1'b0;
			ovf_q   <= 1'b0;
			sat_q   <= 1'b0;
			clr_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == CFG_NUM_SECTIONS) begin
				nsec_q <= cfg_wdata[2:0];
			end
			if (cfg_we && cfg_idx == CFG_OVERFLOW_LIMIT) begin
				limit_q <= cfg_wdata[30:0];
			end
			if (cmd.swap) begin
				bank_q <= !bank_q;
			end
			if (cmd.load_item) begin
				sat_q <= 1'b0;
				clr_q <= 1'b0;
			end else if (cmd.run) begin
				if (do_clr) begin
					ovf_q <= 1'b0;
					clr_q <= 1'b1;
				end
				if (cmd.step == ST_CT || cmd.step == ST_Y) begin
					if (rnd_ovs) begin
						sat_q <= 1'b1;
					end
					if (over_lim) begin
						ovf_q <= 1'b1;
					end
				end
			end
		end
	end

	assign out_sample  = out_sample_q;
	assign out_sat     = out_sat_q;
	assign out_cleared = out_clr_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		do_clr |=> !ovf_q)
		else $error("overflow flag survived a store clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		do_clr |=> clr_q)
		else $error("store clear not reported");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> (!sat_q && !clr_q))
		else $error("item flags not reset on load");

endmodule

>>> rtl/core/cascaded_biquad_filter_core.sv
// channel  | dir | handshake                 | payload
// s_axis   | in  | s_tvalid / s_tready       | s_tdata, s_tuser
// m_axis   | out | m_tvalid / m_tready       | m_tdata, m_tuser
// cfg      | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A sample beat runs the per-section steps for each section in turn (one shared
// 32x32 multiplier, six products plus read, round and write-back steps), then
// loads the result. Coefficient and swap beats are taken without a run.
// Reset clears the delay store valid bits, the bank select and the overflow flag.
// Input is held off while a sample runs; a stalled result holds in its register.
module cascaded_biquad_filter_core #(
	parameter int MAX_SECTIONS = 4,
	parameter int NUM_CHANNELS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // chan, sample_in[23:0], coef_section[1:0], coef_slot[2:0], coef_value[31:0]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // sample_out[31:0]
	output logic [1:0]  m_tuser,   // saturated, store_cleared
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import cbqf_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic signed [31:0] out_sample;
	logic out_sat;
	logic out_clr;

	assign cfg_ready = 1'b1;

	cbqf_ctrl #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_func   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cbqf_dpath #(
		.MAX_SECTIONS(MAX_SECTIONS),
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_idx     (cfg_index),
		.cfg_wdata   (cfg_data),
		.in_chan     (s_tdata[0]),
		.in_sample   (s_tdata[24:1]),
		.in_section  (s_tdata[26:25]),
		.in_slot     (s_tdata[29:27]),
		.in_coef     (s_tdata[61:30]),
		.out_sample  (out_sample),
		.out_sat     (out_sat),
		.out_cleared (out_clr)
	);

	assign m_tdata = out_sample;
	assign m_tuser = {out_clr, out_sat};

endmodule

>>> tb/cascaded_biquad_filter_core_test.sv
`timescale 1ns / 1ps

module cascaded_biquad_filter_core_test;
	import cbqf_pkg::*;

	typedef struct packed {
		logic [1:0]  func;
		logic        chan;
		logic [23:0] sample_in;
		logic [1:0]  coef_section;
		logic [2:0]  coef_slot;
		logic [31:0] coef_value;
	} beat_t;

	typedef struct packed {
		logic [31:0] sample_out;
		logic        saturated;
		logic        store_cleared;
	} filt_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	cascaded_biquad_filter_core dut (.*);

	beat_t     pending_beats[$];
	filt_res_t expected_samples[$];
	int        errors;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        recv_hold;
	bit        in_acc;

	// predictor state
	logic signed [31:0] p_delay[2][4][4];
	logic signed [31:0] p_coef[2][4][6];
	bit                 p_bank;
	bit                 p_ovf;
	logic [2:0]         p_nsec;
	logic [30:0]        p_limit;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint fl28(longint v);
		longint q;
		q = v / (64'sd1 << 28);
		if (v < 0 && q * (64'sd1 << 28) != v)
			q = q - 1;
		return q;
	endfunction

	function automatic longint round_q28(longint p0, longint p1, longint p2);
		longint f0, f1, f2;
		f0 = p0 & 64'hFFF_FFFF;
		f1 = p1 & 64'hFFF_FFFF;
		f2 = p2 & 64'hFFF_FFFF;
		return (p0 - f0) / (64'sd1 << 28) + (p1 - f1) / (64'sd1 << 28) +
			(p2 - f2) / (64'sd1 << 28) + fl28(f0 + f1 + f2 + (64'sd1 << 27));
	endfunction

	function automatic longint clip32(longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	task automatic predict_beat(beat_t b);
		int        n;
		longint    x, ct, y;
		bit        sat, clr;
		filt_res_t r;
		if (b.func == FN_COEF) begin
			if (b.coef_slot < SLOTS)
				p_coef[!p_bank][b.coef_section][b.coef_slot] = b.coef_value;
		end else if (b.func == FN_SWAP) begin
			p_bank = !p_bank;
		end else if (b.func == FN_FILTER) begin
			n = p_nsec == 0 ? 1 : (p_nsec > 4 ? 4 : p_nsec);
			x = longint'($signed(b.sample_in));
			sat = 0;
			clr = 0;
			for (int k = 0; k < n; k++) begin
				if (p_ovf) begin
					p_ovf = 0;
					clr = 1;
					for (int s = 0; s < 4; s++)
						for (int t = 0; t < 4; t++)
							p_delay[b.chan][s][t] = 0;
				end
				ct = clip32(round_q28(x * p_coef[p_bank][k][SLOT_B0],
					longint'(p_coef[p_bank][k][SLOT_B1]) * p_delay[b.chan][k][TAP_X1],
					longint'(p_coef[p_bank][k][SLOT_B2]) * p_delay[b.chan][k][TAP_X2]), sat);
				y = clip32(round_q28(ct * p_coef[p_bank][k][SLOT_A0],
					-(longint'(p_coef[p_bank][k][SLOT_A1]) * p_delay[b.chan][k][TAP_Y1]),
					-(longint'(p_coef[p_bank][k][SLOT_A2]) * p_delay[b.chan][k][TAP_Y2])), sat);
				p_delay[b.chan][k][TAP_X2] = p_delay[b.chan][k][TAP_X1];
				p_delay[b.chan][k][TAP_X1] = 32'(x);
				p_delay[b.chan][k][TAP_Y2] = p_delay[b.chan][k][TAP_Y1];
				p_delay[b.chan][k][TAP_Y1] = 32'(y);
				if (magnitude(ct) > p_limit || magnitude(y) > p_limit)
					p_ovf = 1;
				x = y;
			end
			r.sample_out = x[31:0];
			r.saturated = sat;
			r.store_cleared = clr;
			expected_samples.push_back(r);
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_acc) begin
			if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tdata <= {2'b00, pending_beats[0].coef_value, pending_beats[0].coef_slot,
					pending_beats[0].coef_section, pending_beats[0].sample_in,
					pending_beats[0].chan};
				s_tuser <= pending_beats[0].func;
				s_tvalid <= 1'b1;
				void'(pending_beats.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		beat_t     b;
		filt_res_t got, exp_r;
		in_acc <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			b.func = s_tuser;
			{b.coef_value, b.coef_slot, b.coef_section, b.sample_in, b.chan} = s_tdata[61:0];
			predict_beat(b);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser[0], m_tuser[1]};
			if (expected_samples.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
			end else begin
				exp_r = expected_samples.pop_front();
				if (got !== exp_r) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected out %h sat %b clr %b, got out %h sat %b clr %b",
							exp_r.sample_out, exp_r.saturated, exp_r.store_cleared,
							got.sample_out, got.saturated, got.store_cleared);
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_beats.size() > 0 || s_tvalid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_NUM_SECTIONS)
			p_nsec = value[2:0];
		else
			p_limit = value[30:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic beat_t coef_beat(int sec, logic [2:0] slot, logic [31:0] v);
		beat_t b;
		b = '0;
		b.func = FN_COEF;
		b.coef_section = 2'(sec);
		b.coef_slot = slot;
		b.coef_value = v;
		return b;
	endfunction

	function automatic beat_t sample_beat(logic ch, logic [23:0] s);
		beat_t b;
		b = '0;
		b.func = FN_FILTER;
		b.chan = ch;
		b.sample_in = s;
		return b;
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h2000_0000) - 32'h1000_0000;
			default: return $urandom_range(32'h0800_0000) - 32'h0400_0000;
		endcase
	endfunction

	// load a full bank into the inactive side, then optionally swap
	task automatic queue_bank(bit wild, bit swap_after);
		beat_t b;
		for (int s = 0; s < 4; s++)
			for (int t = 0; t < SLOTS; t++)
				pending_beats.push_back(coef_beat(s, 3'(t), wild ? $urandom : rand_coef()));
		if (swap_after) begin
			b = '0;
			b.func = FN_SWAP;
			pending_beats.push_back(b);
		end
	endtask

	task automatic queue_random(int count);
		beat_t b;
		for (int i = 0; i < count; i++) begin
			b = '0;
			case ($urandom_range(19))
				0: begin
					b = coef_beat($urandom_range(3), 3'($urandom_range(7)), rand_coef());
				end
				1: b.func = FN_SWAP;
				2: begin
					b = $urandom;
					b.coef_value = $urandom;
					b.func = 2'd3;
				end
				default: begin
					b = sample_beat(1'($urandom_range(1)), 24'($urandom));
					if ($urandom_range(3) == 0)
						b.sample_in = 24'($urandom_range(2000) - 1000);
					b.coef_value = $urandom;
					b.coef_slot = 3'($urandom);
				end
			endcase
			pending_beats.push_back(b);
		end
	endtask

	initial begin
		#6000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [31:0] unity;
		beat_t       swap_b;
		unity = 32'h1000_0000;
		swap_b = '0;
		swap_b.func = FN_SWAP;
		errors = 0;
		recv_hold = 0;
		send_idle_pct = 31;
		recv_idle_pct = 88;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		p_delay = '{default: '0};
		p_coef = '{default: '0};
		p_bank = 0;
		p_ovf = 0;
		p_nsec = NUM_SECTIONS_RST;
		p_limit = OVERFLOW_LIMIT_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// write both banks before any sample reads them
		for (int s = 0; s < 4; s++)
			for (int t = 0; t < SLOTS; t++)
				pending_beats.push_back(coef_beat(s, 3'(t),
					(t == SLOT_B0 || t == SLOT_A0) ? unity : 32'h0));
		pending_beats.push_back(swap_b);
		queue_bank(0, 1);
		pending_beats.push_back(coef_beat(1, 3'd6, 32'hFFFF_FFFF));
		pending_beats.push_back(coef_beat(2, 3'd7, 32'h8000_0000));
		pending_beats.push_back(sample_beat(0, 24'h7FFFFF));
		pending_beats.push_back(sample_beat(1, 24'h800000));
		pending_beats.push_back(sample_beat(0, 24'h000000));
		pending_beats.push_back(sample_beat(1, 24'hFFFFFF));
		wait_drained();

		// identity bank with extreme values in the inactive one
		pending_beats.push_back(swap_b);
		queue_bank(1, 0);
		pending_beats.push_back(sample_beat(0, 24'h7FFFFF));
		pending_beats.push_back(sample_beat(1, 24'h800000));
		pending_beats.push_back(sample_beat(0, 24'h123456));
		wait_drained();

		write_reg(CFG_NUM_SECTIONS, 32'd4);
		write_reg(CFG_OVERFLOW_LIMIT, 32'd0);
		queue_bank(0, 1);
		queue_random(150);
		wait_drained();

		write_reg(CFG_NUM_SECTIONS, 32'd0);
		write_reg(CFG_OVERFLOW_LIMIT, 32'h7FFF_FFFF);
		queue_random(150);
		wait_drained();

		send_idle_pct = 88;
		recv_idle_pct = 31;
		write_reg(CFG_NUM_SECTIONS, 32'd7);
		write_reg(CFG_OVERFLOW_LIMIT, 32'hFFFF_FFFF);
		queue_bank(0, 1);
		queue_random(200);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_NUM_SECTIONS, 32'd1);
		write_reg(CFG_OVERFLOW_LIMIT, 32'd5000);
		queue_random(150);
		@(negedge clk);
		recv_hold = 600;
		wait_drained();

		write_reg(CFG_NUM_SECTIONS, 32'd3);
		write_reg(CFG_OVERFLOW_LIMIT, 32'd1000000);
		queue_bank(0, 1);
		queue_random(300);
		wait_drained();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
